[rtl/core/cpa_pkg.sv]
// Shared types and constants for the critical path analysis block.
// Holds the command and result codes, the sizes and the packed transfer structs.
// Depends on nothing.
package cpa_pkg;

    localparam int MAX_NODES   = 128;
    localparam int NODE_W      = 7;
    localparam int CNT_W       = 8;
    localparam int COST_W      = 12;
    localparam int TIME_W      = 20;
    localparam int EDGE_W      = COST_W + 1;
    localparam int EDGE_ADDR_W = 2 * NODE_W;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_COMPUTE = 2'd1;
    localparam logic [1:0] CMD_FETCH   = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [1:0] KIND_INFEASIBLE = 2'd0;
    localparam logic [1:0] KIND_TOTAL      = 2'd1;
    localparam logic [1:0] KIND_ACTIVITY   = 2'd2;
    localparam logic [1:0] KIND_END        = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [COST_W-1:0] cost;
    } cpa_cmd_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [NODE_W-1:0] start_node;
        logic [NODE_W-1:0] end_node;
        logic [TIME_W-1:0] total_time;
        logic              last;
    } cpa_result_t;

endpackage

[rtl/core/critical_path_analysis.sv]
// Critical path analysis of an activity-on-edge network: edge store, sequencer and time tables.
// Depends on cpa_pkg for the command and result codes and the transfer structs.
//
// Usage: a command is taken when start is high and busy is low; compute and fetch each give
// one result, shown for exactly one cycle with result_strobe high, and the receiver cannot
// stall it. A load is written from the idle state and does not raise busy. After reset and
// after a clear command the edge store is swept clean, one entry a cycle, with busy high
// until the sweep ends; node_count writes are still taken then. Compute runs over the edge
// store with one read port through the out-degree and in-degree passes, the queue seeding,
// the forward pass, the maximum search and the backward pass, which scans the row of each
// node that has successors. A fetch walks the store from the saved position through the
// next critical activity and on to the one after it to decide the last flag. A fetch
// without a valid analysis answers in the next cycle and never raises busy.
module critical_path_analysis
    import cpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cpa_cmd_t    cmd_item,
    output cpa_result_t result,
    output logic        result_strobe,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    // Sequencer states: the wipe sweep, the two degree passes, the queue seeding, the
    // forward relaxation, the maximum search, the backward pass and the fetch search.
    typedef enum logic [20:0] {
        S_WIPE     = 21'h000001,
        S_IDLE     = 21'h000002,
        S_OUTD_RD  = 21'h000004,
        S_OUTD_CHK = 21'h000008,
        S_IND_RD   = 21'h000010,
        S_IND_CHK  = 21'h000020,
        S_SEED_RD  = 21'h000040,
        S_SEED_CHK = 21'h000080,
        S_POP_RD   = 21'h000100,
        S_POP_U    = 21'h000200,
        S_REL_RD   = 21'h000400,
        S_REL_CHK  = 21'h000800,
        S_MAX_RD   = 21'h001000,
        S_MAX_CHK  = 21'h002000,
        S_BK_RD    = 21'h004000,
        S_BK_U     = 21'h008000,
        S_BK_D     = 21'h010000,
        S_BK_RD2   = 21'h020000,
        S_BK_CHK   = 21'h040000,
        S_SR_RD    = 21'h080000,
        S_SR_CHK   = 21'h100000
    } cpa_state_t;

    cpa_state_t state_reg, state_next;

    // Control registers.
    logic [CNT_W-1:0]       i_reg, i_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [NODE_W-1:0]      u_reg, u_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       visited_reg, visited_next;
    logic [TIME_W-1:0]      total_reg, total_next;
    logic [TIME_W-1:0]      lu_reg, lu_next;
    logic [CNT_W-1:0]       srow_reg, srow_next;
    logic [NODE_W-1:0]      scol_reg, scol_next;
    logic                   phase_reg, phase_next;
    logic [NODE_W-1:0]      fs_reg, fs_next;
    logic [NODE_W-1:0]      fe_reg, fe_next;
    logic [CNT_W-1:0]       scan_row_reg, scan_row_next;
    logic [NODE_W-1:0]      scan_col_reg, scan_col_next;
    logic                   done_reg, done_next;
    logic [7:0]             nc_reg;
    logic [EDGE_ADDR_W-1:0] wipe_reg, wipe_next;
    cpa_result_t            res_reg, res_next;
    logic                   strobe_reg, strobe_next;

    // Memories and their ports.
    logic [EDGE_W-1:0]      edge_mem [MAX_NODES*MAX_NODES];
    logic [CNT_W-1:0]       ind_mem [MAX_NODES];
    logic [CNT_W-1:0]       outd_mem [MAX_NODES];
    logic [TIME_W-1:0]      e_mem [MAX_NODES];
    logic [TIME_W-1:0]      l_mem [MAX_NODES];
    logic [NODE_W-1:0]      q_mem [MAX_NODES];

    logic                   edge_we;
    logic [EDGE_ADDR_W-1:0] edge_wa, edge_ra;
    logic [EDGE_W-1:0]      edge_wd, edge_rd;
    logic                   ind_we, outd_we, e_we, l_we, q_we;
    logic [NODE_W-1:0]      ind_wa, outd_wa, e_wa, l_wa, q_wa;
    logic [CNT_W-1:0]       ind_wd, outd_wd;
    logic [TIME_W-1:0]      e_wd, l_wd;
    logic [NODE_W-1:0]      q_wd;
    logic [NODE_W-1:0]      ind_ra, outd_ra, ta_ra, tb_ra, q_ra;
    logic [CNT_W-1:0]       ind_rd, outd_rd;
    logic [TIME_W-1:0]      ea_rd, eb_rd, la_rd, lb_rd;
    logic [NODE_W-1:0]      q_rd;

    // Active node count: zero acts as one, anything above the table size is clamped.
    logic [CNT_W-1:0]       n_act, n_m1;
    logic                   cfg_wr;

    // Arithmetic shared by the sequencer states.
    logic [CNT_W-1:0]       cnt_inc;
    logic [TIME_W:0]        fwd_sum;
    logic [TIME_W-1:0]      fwd_t;
    logic [CNT_W-1:0]       deg_dec;
    logic [TIME_W-1:0]      cost_ext;
    logic                   lb_ge;
    logic [TIME_W-1:0]      lb_sub;
    logic [TIME_W-1:0]      bk_t;
    logic                   crit;
    logic [CNT_W-1:0]       arow;
    logic [NODE_W-1:0]      acol;
    logic                   j_end, i_end;

    assign cfg_ready     = 1'b1;
    assign cfg_wr        = cfg_valid & cfg_ready;
    assign busy          = (state_reg != S_IDLE);
    assign result        = res_reg;
    assign result_strobe = strobe_reg;

    always_comb
    begin
        if (nc_reg == 8'd0)
        begin
            n_act = 8'd1;
        end
        else if (nc_reg > CNT_W'(MAX_NODES))
        begin
            n_act = CNT_W'(MAX_NODES);
        end
        else
        begin
            n_act = nc_reg;
        end
    end

    assign n_m1     = n_act - 8'd1;
    assign j_end    = (j_reg == n_m1);
    assign i_end    = (i_reg == n_m1);
    assign cnt_inc  = cnt_reg + CNT_W'(edge_rd[COST_W]);
    assign cost_ext = TIME_W'(edge_rd[COST_W-1:0]);
    assign fwd_sum  = {1'b0, ea_rd} + {1'b0, cost_ext};
    assign fwd_t    = fwd_sum[TIME_W] ? TIME_MAX : fwd_sum[TIME_W-1:0];
    assign deg_dec  = ind_rd - 8'd1;
    assign lb_ge    = (lb_rd >= cost_ext);
    assign lb_sub   = lb_rd - cost_ext;
    assign bk_t     = lb_ge ? lb_sub : '0;
    // An activity is critical when both ends have no slack and it fills the gap exactly.
    assign crit     = edge_rd[COST_W] && (ea_rd == la_rd) && (eb_rd == lb_rd) && lb_ge
                      && (lb_sub == ea_rd);
    assign arow     = (scol_reg == '0) ? (srow_reg + 8'd1) : srow_reg;
    assign acol     = (scol_reg == '0) ? n_m1[NODE_W-1:0] : (scol_reg - 7'd1);

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        u_next        = u_reg;
        cnt_next      = cnt_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        visited_next  = visited_reg;
        total_next    = total_reg;
        lu_next       = lu_reg;
        srow_next     = srow_reg;
        scol_next     = scol_reg;
        phase_next    = phase_reg;
        fs_next       = fs_reg;
        fe_next       = fe_reg;
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        done_next     = done_reg;
        wipe_next     = wipe_reg;
        res_next      = res_reg;
        strobe_next   = 1'b0;

        edge_we = 1'b0;
        edge_wa = '0;
        edge_wd = '0;
        edge_ra = '0;
        ind_we  = 1'b0;
        ind_wa  = '0;
        ind_wd  = '0;
        ind_ra  = '0;
        outd_we = 1'b0;
        outd_wa = '0;
        outd_wd = '0;
        outd_ra = '0;
        e_we    = 1'b0;
        e_wa    = '0;
        e_wd    = '0;
        l_we    = 1'b0;
        l_wa    = '0;
        l_wd    = '0;
        ta_ra   = '0;
        tb_ra   = '0;
        q_we    = 1'b0;
        q_wa    = '0;
        q_wd    = '0;
        q_ra    = '0;

        unique case (state_reg)
            S_WIPE:
            begin
                edge_we   = 1'b1;
                edge_wa   = wipe_reg;
                wipe_next = wipe_reg + EDGE_ADDR_W'(1);
                if (wipe_reg == {EDGE_ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_item.cmd)
                        CMD_LOAD:
                        begin
                            edge_we   = 1'b1;
                            edge_wa   = {cmd_item.from_node, cmd_item.to_node};
                            edge_wd   = {1'b1, cmd_item.cost};
                            done_next = 1'b0;
                        end
                        CMD_COMPUTE:
                        begin
                            i_next        = '0;
                            j_next        = '0;
                            cnt_next      = '0;
                            done_next     = 1'b0;
                            scan_row_next = '0;
                            scan_col_next = '1;
                            state_next    = S_OUTD_RD;
                        end
                        CMD_FETCH:
                        begin
                            if (!done_reg)
                            begin
                                res_next    = '{KIND_END, '0, '0, '0, 1'b1};
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                srow_next  = scan_row_reg;
                                scol_next  = ({1'b0, scan_col_reg} >= n_act) ?
                                             n_m1[NODE_W-1:0] : scan_col_reg;
                                phase_next = 1'b0;
                                state_next = S_SR_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            wipe_next     = '0;
                            done_next     = 1'b0;
                            scan_row_next = '0;
                            scan_col_next = '1;
                            state_next    = S_WIPE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_OUTD_RD:
            begin
                edge_ra    = {i_reg[NODE_W-1:0], j_reg[NODE_W-1:0]};
                state_next = S_OUTD_CHK;
            end
            S_OUTD_CHK:
            begin
                state_next = S_OUTD_RD;
                if (j_end)
                begin
                    outd_we  = 1'b1;
                    outd_wa  = i_reg[NODE_W-1:0];
                    outd_wd  = cnt_inc;
                    cnt_next = '0;
                    j_next   = '0;
                    if (i_end)
                    begin
                        i_next     = '0;
                        state_next = S_IND_RD;
                    end
                    else
                    begin
                        i_next = i_reg + 8'd1;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                    j_next   = j_reg + 8'd1;
                end
            end
            S_IND_RD:
            begin
                // Column scan: row j, column i.
                edge_ra    = {j_reg[NODE_W-1:0], i_reg[NODE_W-1:0]};
                state_next = S_IND_CHK;
            end
            S_IND_CHK:
            begin
                state_next = S_IND_RD;
                if (j_end)
                begin
                    ind_we   = 1'b1;
                    ind_wa   = i_reg[NODE_W-1:0];
                    ind_wd   = cnt_inc;
                    e_we     = 1'b1;
                    e_wa     = i_reg[NODE_W-1:0];
                    l_we     = 1'b1;
                    l_wa     = i_reg[NODE_W-1:0];
                    l_wd     = TIME_MAX;
                    cnt_next = '0;
                    j_next   = '0;
                    if (i_end)
                    begin
                        i_next       = '0;
                        head_next    = '0;
                        tail_next    = '0;
                        visited_next = '0;
                        state_next   = S_SEED_RD;
                    end
                    else
                    begin
                        i_next = i_reg + 8'd1;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                    j_next   = j_reg + 8'd1;
                end
            end
            S_SEED_RD:
            begin
                ind_ra     = i_reg[NODE_W-1:0];
                state_next = S_SEED_CHK;
            end
            S_SEED_CHK:
            begin
                if (ind_rd == '0)
                begin
                    q_we      = 1'b1;
                    q_wa      = tail_reg[NODE_W-1:0];
                    q_wd      = i_reg[NODE_W-1:0];
                    tail_next = tail_reg + 8'd1;
                end
                if (i_end)
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    i_next     = i_reg + 8'd1;
                    state_next = S_SEED_RD;
                end
            end
            S_POP_RD:
            begin
                if (head_reg < tail_reg)
                begin
                    q_ra       = head_reg[NODE_W-1:0];
                    head_next  = head_reg + 8'd1;
                    state_next = S_POP_U;
                end
                else if (visited_reg != n_act)
                begin
                    // Some node never became ready: the graph has a cycle.
                    res_next    = '{KIND_INFEASIBLE, '0, '0, '0, 1'b0};
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    i_next     = '0;
                    total_next = '0;
                    state_next = S_MAX_RD;
                end
            end
            S_POP_U:
            begin
                u_next       = q_rd;
                visited_next = visited_reg + 8'd1;
                j_next       = '0;
                state_next   = S_REL_RD;
            end
            S_REL_RD:
            begin
                edge_ra    = {u_reg, j_reg[NODE_W-1:0]};
                ta_ra      = u_reg;
                tb_ra      = j_reg[NODE_W-1:0];
                ind_ra     = j_reg[NODE_W-1:0];
                state_next = S_REL_CHK;
            end
            S_REL_CHK:
            begin
                if (edge_rd[COST_W])
                begin
                    e_we   = 1'b1;
                    e_wa   = j_reg[NODE_W-1:0];
                    e_wd   = (fwd_t > eb_rd) ? fwd_t : eb_rd;
                    ind_we = 1'b1;
                    ind_wa = j_reg[NODE_W-1:0];
                    ind_wd = deg_dec;
                    if ((deg_dec == '0) && (tail_reg < CNT_W'(MAX_NODES)))
                    begin
                        q_we      = 1'b1;
                        q_wa      = tail_reg[NODE_W-1:0];
                        q_wd      = j_reg[NODE_W-1:0];
                        tail_next = tail_reg + 8'd1;
                    end
                end
                if (j_end)
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    j_next     = j_reg + 8'd1;
                    state_next = S_REL_RD;
                end
            end
            S_MAX_RD:
            begin
                ta_ra      = i_reg[NODE_W-1:0];
                state_next = S_MAX_CHK;
            end
            S_MAX_CHK:
            begin
                if (ea_rd > total_reg)
                begin
                    total_next = ea_rd;
                end
                if (i_end)
                begin
                    i_next     = n_act;
                    state_next = S_BK_RD;
                end
                else
                begin
                    i_next     = i_reg + 8'd1;
                    state_next = S_MAX_RD;
                end
            end
            S_BK_RD:
            begin
                // Walk the topological order backwards; i counts down from n.
                q_ra       = 7'(i_reg - 8'd1);
                state_next = S_BK_U;
            end
            S_BK_U:
            begin
                u_next     = q_rd;
                outd_ra    = q_rd;
                state_next = S_BK_D;
            end
            S_BK_D:
            begin
                if (outd_rd == '0)
                begin
                    l_we   = 1'b1;
                    l_wa   = u_reg;
                    l_wd   = total_reg;
                    i_next = i_reg - 8'd1;
                    if (i_reg == 8'd1)
                    begin
                        scan_row_next = '0;
                        scan_col_next = n_m1[NODE_W-1:0];
                        done_next     = 1'b1;
                        res_next      = '{KIND_TOTAL, '0, '0, total_reg, 1'b0};
                        strobe_next   = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_BK_RD;
                    end
                end
                else
                begin
                    lu_next    = TIME_MAX;
                    j_next     = '0;
                    state_next = S_BK_RD2;
                end
            end
            S_BK_RD2:
            begin
                edge_ra    = {u_reg, j_reg[NODE_W-1:0]};
                tb_ra      = j_reg[NODE_W-1:0];
                state_next = S_BK_CHK;
            end
            S_BK_CHK:
            begin
                lu_next = (edge_rd[COST_W] && (bk_t < lu_reg)) ? bk_t : lu_reg;
                if (j_end)
                begin
                    l_we   = 1'b1;
                    l_wa   = u_reg;
                    l_wd   = lu_next;
                    i_next = i_reg - 8'd1;
                    if (i_reg == 8'd1)
                    begin
                        scan_row_next = '0;
                        scan_col_next = n_m1[NODE_W-1:0];
                        done_next     = 1'b1;
                        res_next      = '{KIND_TOTAL, '0, '0, total_reg, 1'b0};
                        strobe_next   = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_BK_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 8'd1;
                    state_next = S_BK_RD2;
                end
            end
            S_SR_RD:
            begin
                if (srow_reg >= n_act)
                begin
                    // Search ran off the last row.
                    if (!phase_reg)
                    begin
                        scan_row_next = srow_reg;
                        scan_col_next = n_m1[NODE_W-1:0];
                        res_next      = '{KIND_END, '0, '0, '0, 1'b1};
                    end
                    else
                    begin
                        res_next = '{KIND_ACTIVITY, fs_reg, fe_reg, '0, 1'b1};
                    end
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    edge_ra    = {srow_reg[NODE_W-1:0], scol_reg};
                    ta_ra      = srow_reg[NODE_W-1:0];
                    tb_ra      = scol_reg;
                    state_next = S_SR_CHK;
                end
            end
            S_SR_CHK:
            begin
                srow_next  = arow;
                scol_next  = acol;
                state_next = S_SR_RD;
                if (crit)
                begin
                    if (!phase_reg)
                    begin
                        // Found the activity to report; look ahead for the last flag.
                        fs_next       = srow_reg[NODE_W-1:0];
                        fe_next       = scol_reg;
                        scan_row_next = arow;
                        scan_col_next = acol;
                        phase_next    = 1'b1;
                    end
                    else
                    begin
                        res_next    = '{KIND_ACTIVITY, fs_reg, fe_reg, '0, 1'b0};
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_WIPE;
            i_reg        <= '0;
            j_reg        <= '0;
            u_reg        <= '0;
            cnt_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            visited_reg  <= '0;
            srow_reg     <= '0;
            scol_reg     <= '0;
            phase_reg    <= 1'b0;
            scan_row_reg <= '0;
            scan_col_reg <= '1;
            done_reg     <= 1'b0;
            nc_reg       <= 8'd1;
            wipe_reg     <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            u_reg        <= u_next;
            cnt_reg      <= cnt_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            visited_reg  <= visited_next;
            srow_reg     <= srow_next;
            scol_reg     <= scol_next;
            phase_reg    <= phase_next;
            scan_row_reg <= scan_row_next;
            scan_col_reg <= scan_col_next;
            wipe_reg     <= wipe_next;
            strobe_reg   <= strobe_next;
            // A node count write always invalidates the analysis.
            if (cfg_wr)
            begin
                nc_reg   <= cfg_data;
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        lu_reg    <= lu_next;
        fs_reg    <= fs_next;
        fe_reg    <= fe_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_wa] <= edge_wd;
        end
        edge_rd <= edge_mem[edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ind_we)
        begin
            ind_mem[ind_wa] <= ind_wd;
        end
        ind_rd <= ind_mem[ind_ra];
    end

    always_ff @(posedge clk)
    begin
        if (outd_we)
        begin
            outd_mem[outd_wa] <= outd_wd;
        end
        outd_rd <= outd_mem[outd_ra];
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            e_mem[e_wa] <= e_wd;
        end
        ea_rd <= e_mem[ta_ra];
        eb_rd <= e_mem[tb_ra];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            l_mem[l_wa] <= l_wd;
        end
        la_rd <= l_mem[ta_ra];
        lb_rd <= l_mem[tb_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        q_rd <= q_mem[q_ra];
    end

endmodule

[verif/cpa_checker.sv]
// Checker for the critical path analysis block: watches the command, result and
// configuration channels, predicts each result and compares it with the block's output.
// Depends on cpa_pkg for the transfer structs, sizes and codes.
module cpa_checker
    import cpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  cpa_cmd_t    cmd_item,
    input  cpa_result_t result,
    input  logic        result_strobe,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          totals_seen,
    output int          infeasible_seen,
    output int          activities_seen
);

    logic [EDGE_W-1:0] cost_store [MAX_NODES*MAX_NODES];
    int          in_deg [MAX_NODES];
    int          out_deg [MAX_NODES];
    int          early_time [MAX_NODES];
    int          late_time [MAX_NODES];
    int          topo_order [MAX_NODES];
    int          q_head, q_tail, visited, row_pos, col_pos;
    bit          analysis_valid;
    logic [7:0]  node_reg;
    cpa_result_t expected_q [$];

    function automatic int nodes_in_use();
        if (node_reg == 0) return 1;
        if (node_reg > MAX_NODES) return MAX_NODES;
        return int'(node_reg);
    endfunction

    function automatic bit on_critical(int u, int v);
        logic [EDGE_W-1:0] e;
        int c;
        e = cost_store[u*MAX_NODES + v];
        c = int'(e[COST_W-1:0]);
        if (!e[COST_W]) return 0;
        if (early_time[u] != late_time[u] || early_time[v] != late_time[v]) return 0;
        if (late_time[v] < c) return 0;
        return (late_time[v] - c) == early_time[u];
    endfunction

    // Walks end nodes downward, then moves on to the next start node.
    function automatic bit next_critical(int n, inout int r, inout int c);
        int row, col;
        row = r;
        col = c;
        while (row < n)
        begin
            if (col >= n) col = n - 1;
            forever
            begin
                if (on_critical(row, col))
                begin
                    r = row;
                    c = col;
                    return 1;
                end
                if (col == 0) break;
                col--;
            end
            row++;
            col = n - 1;
        end
        r = row;
        c = n - 1;
        return 0;
    endfunction

    function automatic void clear_times();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            in_deg[i] = 0;
            out_deg[i] = 0;
            early_time[i] = 0;
            late_time[i] = int'(TIME_MAX);
            topo_order[i] = 0;
        end
        q_head = 0;
        q_tail = 0;
        visited = 0;
        row_pos = 0;
        col_pos = 'h7F;
        analysis_valid = 0;
    endfunction

    function automatic void clear_graph();
        foreach (cost_store[i]) cost_store[i] = '0;
        clear_times();
    endfunction

    function automatic cpa_result_t analyze();
        cpa_result_t res;
        int n, u, t, c, total;
        logic [EDGE_W-1:0] e;
        res = '0;
        n = nodes_in_use();
        total = 0;
        clear_times();
        for (u = 0; u < n; u++)
            for (int v = 0; v < n; v++)
                if (cost_store[u*MAX_NODES + v][COST_W])
                begin
                    out_deg[u]++;
                    in_deg[v]++;
                end
        for (u = 0; u < n; u++)
            if (in_deg[u] == 0) topo_order[q_tail++] = u;
        while (q_head < q_tail && q_head < MAX_NODES)
        begin
            u = topo_order[q_head++];
            visited++;
            for (int v = 0; v < n; v++)
            begin
                e = cost_store[u*MAX_NODES + v];
                if (!e[COST_W]) continue;
                t = early_time[u] + int'(e[COST_W-1:0]);
                if (t > int'(TIME_MAX)) t = int'(TIME_MAX);
                if (t > early_time[v]) early_time[v] = t;
                in_deg[v]--;
                if (in_deg[v] == 0 && q_tail < MAX_NODES) topo_order[q_tail++] = v;
            end
        end
        if (visited != n)
        begin
            res.kind = KIND_INFEASIBLE;
            return res;
        end
        for (u = 0; u < n; u++)
            if (early_time[u] > total) total = early_time[u];
        // Latest times are settled in reverse topological order.
        for (int k = n; k > 0; k--)
        begin
            u = topo_order[k-1];
            if (out_deg[u] == 0)
            begin
                late_time[u] = total;
                continue;
            end
            for (int v = 0; v < n; v++)
            begin
                e = cost_store[u*MAX_NODES + v];
                if (!e[COST_W]) continue;
                c = int'(e[COST_W-1:0]);
                t = (late_time[v] >= c) ? late_time[v] - c : 0;
                if (t < late_time[u]) late_time[u] = t;
            end
        end
        row_pos = 0;
        col_pos = n - 1;
        analysis_valid = 1;
        res.kind = KIND_TOTAL;
        res.total_time = TIME_W'(total);
        return res;
    endfunction

    function automatic cpa_result_t fetch_next();
        cpa_result_t res;
        int n, r, c, lr, lc;
        res = '0;
        n = nodes_in_use();
        r = row_pos;
        c = col_pos;
        if (!analysis_valid || !next_critical(n, r, c))
        begin
            row_pos = r;
            col_pos = c & 'h7F;
            res.kind = KIND_END;
            res.last = 1'b1;
            return res;
        end
        res.kind = KIND_ACTIVITY;
        res.start_node = NODE_W'(r);
        res.end_node = NODE_W'(c);
        if (c == 0)
        begin
            r++;
            c = n - 1;
        end
        else
        begin
            c--;
        end
        row_pos = r;
        col_pos = c;
        lr = r;
        lc = c;
        res.last = !next_critical(n, lr, lc);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cpa_result_t exp_res;
        if (!rst_n)
        begin
            clear_graph();
            node_reg = 8'd1;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
            totals_seen = 0;
            infeasible_seen = 0;
            activities_seen = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result kind=%0d", $realtime, result.kind);
                end
                else
                begin
                    exp_res = expected_q.pop_front();
                    if (result.kind !== exp_res.kind || result.start_node !== exp_res.start_node
                        || result.end_node !== exp_res.end_node
                        || result.total_time !== exp_res.total_time
                        || result.last !== exp_res.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch expected kind=%0d start=%0d end=%0d ",
                                      "time=%0d last=%0d, got kind=%0d start=%0d end=%0d ",
                                      "time=%0d last=%0d"},
                                $realtime, exp_res.kind, exp_res.start_node, exp_res.end_node,
                                exp_res.total_time, exp_res.last, result.kind,
                                result.start_node, result.end_node, result.total_time,
                                result.last);
                    end
                    case (exp_res.kind)
                        KIND_TOTAL:      totals_seen++;
                        KIND_INFEASIBLE: infeasible_seen++;
                        KIND_ACTIVITY:   activities_seen++;
                        default: ;
                    endcase
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                node_reg = cfg_data;
                analysis_valid = 0;
            end
            if (start && !busy)
            begin
                case (cmd_item.cmd)
                    CMD_LOAD:
                    begin
                        cost_store[cmd_item.from_node*MAX_NODES + cmd_item.to_node] =
                            {1'b1, cmd_item.cost};
                        analysis_valid = 0;
                    end
                    CMD_COMPUTE: expected_q.push_back(analyze());
                    CMD_FETCH:   expected_q.push_back(fetch_next());
                    default:     clear_graph();
                endcase
            end
            pending = expected_q.size();
        end
    end

endmodule

[verif/tb_critical_path_analysis.sv]
// Testbench top for the critical path analysis block: makes clock, reset and stimulus,
// and gives the verdict. Depends on cpa_pkg, critical_path_analysis and cpa_checker.
module tb_critical_path_analysis;
    import cpa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cpa_cmd_t    cmd_item;
    cpa_result_t result;
    logic        result_strobe;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int fail_count, pending, totals_seen, infeasible_seen, activities_seen;
    int items_sent;
    int sender_idle;
    int cycle_phases;

    critical_path_analysis i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd_item      (cmd_item),
        .result        (result),
        .result_strobe (result_strobe),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    cpa_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd_item        (cmd_item),
        .result          (result),
        .result_strobe   (result_strobe),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .totals_seen     (totals_seen),
        .infeasible_seen (infeasible_seen),
        .activities_seen (activities_seen)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Sends one command. It is entered at a falling edge and returns at the falling edge
    // after the transfer, with start still high, so that a following command can go out
    // back to back. Whoever waits on anything else lowers start first.
    task automatic issue(input logic [1:0] op, input int from_n, input int to_n,
                         input int dur);
        cpa_cmd_t item;
        int gap;
        item.cmd = op;
        item.from_node = NODE_W'(from_n);
        item.to_node = NODE_W'(to_n);
        item.cost = COST_W'(dur);
        gap = 0;
        while ($urandom_range(99) < sender_idle && gap < 20) gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd_item <= item;
        do @(posedge clk); while (busy);
        @(negedge clk);
        items_sent++;
    endtask

    // The register is written only with the block idle: every expected result in and
    // busy low, which also covers loads, clears and the sweep after reset.
    task automatic write_node_count(input logic [7:0] value);
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase();
        int n, r, nl, nf, u, v, dur;
        bit with_cycle;
        r = $urandom_range(99);
        if (r < 85) n = $urandom_range(2, 12);
        else if (r < 92) n = $urandom_range(0, 1);
        else n = $urandom_range(13, 40);
        write_node_count(8'(n));
        // A phase that closes a cycle must clear afterwards, and a clear sweeps the whole
        // store, so only a couple of them are allowed.
        with_cycle = (n >= 2 && cycle_phases < 2 && $urandom_range(15) == 0);
        nl = (n >= 2) ? $urandom_range(1, 2 * n) : 0;
        for (int i = 0; i < nl; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                // Noise: a fetch on a stale analysis with random field contents.
                issue(CMD_FETCH, $urandom_range(127), $urandom_range(127), $urandom_range(4095));
            end
            else
            begin
                // Edges always go from a lower to a higher node, so the stored graph stays
                // acyclic across phases unless a cycle is made on purpose.
                u = $urandom_range(0, n - 2);
                v = ($urandom_range(9) == 0) ? $urandom_range(u + 1, 127)
                                             : $urandom_range(u + 1, n - 1);
                dur = $urandom_range(1) ? $urandom_range(0, 20) : $urandom_range(4095);
                issue(CMD_LOAD, u, v, dur);
            end
        end
        if (with_cycle)
        begin
            u = $urandom_range(0, n - 2);
            v = $urandom_range(u + 1, n - 1);
            issue(CMD_LOAD, u, v, $urandom_range(4095));
            issue(CMD_LOAD, v, u, $urandom_range(4095));
        end
        issue(CMD_COMPUTE, $urandom_range(127), $urandom_range(127), $urandom_range(4095));
        if ($urandom_range(9) == 0)
            issue(CMD_COMPUTE, $urandom_range(127), $urandom_range(127), $urandom_range(4095));
        nf = $urandom_range(1, nl + 2);
        for (int i = 0; i < nf; i++)
            issue(CMD_FETCH, $urandom_range(127), $urandom_range(127), $urandom_range(4095));
        if (with_cycle)
        begin
            issue(CMD_CLEAR, $urandom_range(127), $urandom_range(127), $urandom_range(4095));
            cycle_phases++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        items_sent = 0;
        cycle_phases = 0;
        sender_idle = 35;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A node count of zero acts as a single node: time zero and no activities.
        write_node_count(8'd0);
        issue(CMD_COMPUTE, 0, 0, 0);
        issue(CMD_FETCH, 0, 0, 0);

        // Small network with a replaced cost and the largest cost.
        write_node_count(8'd6);
        issue(CMD_LOAD, 0, 1, 3);
        issue(CMD_LOAD, 0, 2, 4095);
        issue(CMD_LOAD, 1, 3, 5);
        issue(CMD_LOAD, 2, 3, 0);
        issue(CMD_LOAD, 3, 4, 7);
        issue(CMD_LOAD, 1, 4, 2);
        issue(CMD_LOAD, 0, 1, 6);
        // A fetch before any compute finds no valid analysis.
        issue(CMD_FETCH, 0, 0, 0);
        issue(CMD_COMPUTE, 0, 0, 0);
        repeat (5) issue(CMD_FETCH, 127, 127, 4095);
        // A load makes the analysis stale.
        issue(CMD_LOAD, 4, 5, 1);
        issue(CMD_FETCH, 0, 0, 0);

        // A count above the node limit acts as the limit; a largest-cost edge joins the top two nodes.
        write_node_count(8'd255);
        issue(CMD_LOAD, 126, 127, 4095);
        issue(CMD_COMPUTE, 0, 0, 0);
        issue(CMD_FETCH, 0, 0, 0);
        issue(CMD_FETCH, 0, 0, 0);

        // A self loop on the top node makes the full-size graph infeasible.
        write_node_count(8'd128);
        issue(CMD_LOAD, 127, 127, 4095);
        issue(CMD_COMPUTE, 0, 0, 0);
        issue(CMD_FETCH, 0, 0, 0);
        issue(CMD_CLEAR, 0, 0, 0);

        while (items_sent < 1700)
        begin
            if (items_sent < 567) sender_idle = 35;
            else if (items_sent < 1134) sender_idle = 84;
            else sender_idle = 0;
            random_phase();
        end

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);

        $display("Sent %0d commands over several node counts, with and without sender gaps.",
                 items_sent);
        $display("Checked %0d project times, %0d infeasible graphs, %0d critical activities.",
                 totals_seen, infeasible_seen, activities_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Well beyond the slowest correct run: reset and clear sweeps, two full-size computes
    // and fetches, and many small phases.
    initial
    begin
        #(12 * 4000000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
